### design/tcua_pkg.sv
// Shared constants, codes and types for the thread CPU usage accounting core.
package tcua_pkg;

  localparam int THREADS_DEF  = 16;
  localparam int FRAC_DEF     = 8;

  localparam int TIME_W       = 48;
  localparam int RT_W         = 40;
  localparam int WIN_W        = 32;
  localparam int TICK_W       = 20;
  localparam int TID_W        = 4;
  localparam int ACT_W        = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [ACT_W-1:0] ACT_SWITCH    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_IDLE_CHK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CREATE    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DELETE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 2'd2;

  localparam logic [WIN_W-1:0]  WINDOW_RST = 32'd1000000;
  localparam logic [TICK_W-1:0] TICK_RST   = 20'd1000;
  localparam logic [TID_W-1:0]  IDLE_RST   = 4'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SW_ADJ,
    ST_SW_DELTA,
    ST_SW_ACC,
    ST_CREATE,
    ST_DELETE,
    ST_IC_SPAN,
    ST_IC_CHECK,
    ST_RD,
    ST_MUL,
    ST_PRE,
    ST_DIV,
    ST_WR,
    ST_FIN,
    ST_RES
  } state_t;

endpackage

### design/thread_cpu_usage_accounting_core.sv
// Thread CPU usage accounting core: run-time table, switch charging, windowed share divider.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid/in_ready, action, thread_id, time_us  | input
//  out     | out_valid/out_ready, busy_percent/valid, closed | output
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data        | input
//
// Switch-out steps through ST_SW_ADJ, ST_SW_DELTA and ST_SW_ACC, then ST_FIN and ST_RES.
// Idle check: ST_IC_SPAN, ST_IC_CHECK and, when the window closes, a pass over every slot
// that skips invalid slots and bypasses the division where the share saturates early;
// the shared restoring divider retires one quotient bit per cycle.
// Reset is synchronous; no clearing pass. A pending result does not block the next
// input transfer; a new result waits in ST_RES until the output register is free.
module thread_cpu_usage_accounting_core #(
  parameter int THREADS       = tcua_pkg::THREADS_DEF,
  parameter int FRACTION_BITS = tcua_pkg::FRAC_DEF,
  parameter int SHARE_W       = $clog2((100 << FRACTION_BITS) + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tcua_pkg::ACT_W-1:0]      in_action,
  input  logic [tcua_pkg::TID_W-1:0]      in_thread_id,
  input  logic [tcua_pkg::TIME_W-1:0]     in_time_us,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [SHARE_W-1:0]              out_busy_percent,
  output logic                            out_busy_valid,
  output logic                            out_window_closed,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcua_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcua_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcua_pkg::*;

  localparam int ID_W   = $clog2(THREADS);
  localparam int PROD_W = RT_W + SHARE_W;
  localparam int CNT_W  = $clog2(SHARE_W);
  localparam logic [SHARE_W-1:0] FULL_SCALE = SHARE_W'(100 << FRACTION_BITS);
  localparam logic [8:0]         THREADS_V  = 9'(THREADS);

  state_t state_r, state_nxt;

  logic [TID_W-1:0]   id_r;
  logic [TIME_W-1:0]  now_r;
  logic [WIN_W-1:0]   win_r;
  logic [TICK_W-1:0]  tick_r;
  logic [TID_W-1:0]   idle_r;

  logic [THREADS-1:0] valid_r, valid_nxt;
  logic [TIME_W-1:0]  last_sw_r, last_sw_nxt;
  logic [TIME_W-1:0]  last_win_r, last_win_nxt;
  logic [TIME_W-1:0]  adj_r, adj_nxt;
  logic [TIME_W-1:0]  delta_r, delta_nxt;
  logic [TIME_W:0]    span_r, span_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [TIME_W:0]    rem_r, rem_nxt;
  logic [SHARE_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ID_W-1:0]    idx_r, idx_nxt;
  logic               sat_r, sat_nxt;
  logic               closed_r, closed_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [SHARE_W-1:0] out_busy_r, out_busy_nxt;
  logic               out_bvalid_r, out_bvalid_nxt;
  logic               out_closed_r, out_closed_nxt;

  logic [RT_W-1:0]    rt_mem [THREADS];
  logic [SHARE_W-1:0] sh_mem [THREADS];
  logic [RT_W-1:0]    rt_rd_r;
  logic [SHARE_W-1:0] sh_rd_r;

  logic               rt_we, sh_we;
  logic [ID_W-1:0]    rt_wa, sh_wa, rt_ra;
  logic [RT_W-1:0]    rt_wd;
  logic [SHARE_W-1:0] sh_wd;

  logic [ID_W-1:0]    id_idx, idle_idx;
  logic               id_ok, idle_ok, idx_last, res_load;
  logic [TIME_W:0]    adj_sum, dlt_diff, span_diff, div_trial, div_sub;
  logic [TIME_W-1:0]  adj_val;
  logic [TIME_W:0]    acc_sum;
  logic [RT_W-1:0]    acc_sat;
  logic               win_ok, pre_sat, div_ge, busy_ok;
  logic [SHARE_W-1:0] share_val;

  assign id_idx    = ID_W'({{ID_W{1'b0}}, id_r});
  assign idle_idx  = ID_W'({{ID_W{1'b0}}, idle_r});
  assign id_ok     = {5'b0, id_r} < THREADS_V;
  assign idle_ok   = {5'b0, idle_r} < THREADS_V;
  assign idx_last  = (idx_r == ID_W'(THREADS - 1));

  assign adj_sum   = {1'b0, now_r} + {29'b0, tick_r};
  assign adj_val   = (now_r < last_sw_r) ? (adj_sum[TIME_W] ? '1 : adj_sum[TIME_W-1:0]) : now_r;
  assign dlt_diff  = {1'b0, adj_r} - {1'b0, last_sw_r};
  assign acc_sum   = {9'b0, rt_rd_r} + {1'b0, delta_r};
  assign acc_sat   = (|acc_sum[TIME_W:RT_W]) ? '1 : acc_sum[RT_W-1:0];
  assign span_diff = {1'b0, now_r} - {1'b0, last_win_r};
  assign win_ok    = !span_r[TIME_W] && (span_r[TIME_W-1:0] != '0) &&
                     (span_r[TIME_W-1:0] >= {16'b0, win_r});
  assign pre_sat   = {8'b0, prod_r[PROD_W-1:SHARE_W]} >= span_r[TIME_W-1:0];
  assign div_trial = {rem_r[TIME_W-1:0], prod_r[SHARE_W-1]};
  assign div_ge    = div_trial >= {1'b0, span_r[TIME_W-1:0]};
  assign div_sub   = div_trial - {1'b0, span_r[TIME_W-1:0]};
  assign share_val = (sat_r || (quo_r > FULL_SCALE)) ? FULL_SCALE : quo_r;
  assign busy_ok   = idle_ok && valid_r[idle_idx];
  assign res_load  = (state_r == ST_RES) && (!out_valid_r || out_ready);

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_busy_percent  = out_busy_r;
  assign out_busy_valid    = out_bvalid_r;
  assign out_window_closed = out_closed_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_SWITCH:   state_nxt = ST_SW_ADJ;
            ACT_IDLE_CHK: state_nxt = ST_IC_SPAN;
            ACT_CREATE:   state_nxt = ST_CREATE;
            default:      state_nxt = ST_DELETE;
          endcase
        end
      end
      ST_SW_ADJ:   state_nxt = ST_SW_DELTA;
      ST_SW_DELTA: state_nxt = ST_SW_ACC;
      ST_SW_ACC:   state_nxt = ST_FIN;
      ST_CREATE:   state_nxt = ST_FIN;
      ST_DELETE:   state_nxt = ST_FIN;
      ST_IC_SPAN:  state_nxt = ST_IC_CHECK;
      ST_IC_CHECK: state_nxt = win_ok ? ST_RD : ST_FIN;
      ST_RD: begin
        if (valid_r[idx_r]) begin
          state_nxt = ST_MUL;
        end else if (idx_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_MUL:      state_nxt = ST_PRE;
      ST_PRE:      state_nxt = pre_sat ? ST_WR : ST_DIV;
      ST_DIV: begin
        if (cnt_r == CNT_W'(SHARE_W - 1)) begin
          state_nxt = ST_WR;
        end
      end
      ST_WR:       state_nxt = idx_last ? ST_FIN : ST_RD;
      ST_FIN:      state_nxt = ST_RES;
      ST_RES: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rt_we    = 1'b0;
    rt_wa    = id_idx;
    rt_wd    = '0;
    sh_we    = 1'b0;
    sh_wa    = id_idx;
    sh_wd    = '0;
    rt_ra    = id_idx;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_SW_ACC: begin
        rt_we = id_ok && valid_r[id_idx];
        rt_wd = acc_sat;
      end
      ST_CREATE: begin
        rt_we = id_ok;
        sh_we = id_ok;
      end
      ST_RD:     rt_ra = idx_r;
      ST_WR: begin
        rt_we = 1'b1;
        rt_wa = idx_r;
        sh_we = 1'b1;
        sh_wa = idx_r;
        sh_wd = share_val;
      end
      default: ;
    endcase
  end

  always_comb begin
    valid_nxt      = valid_r;
    last_sw_nxt    = last_sw_r;
    last_win_nxt   = last_win_r;
    adj_nxt        = adj_r;
    delta_nxt      = delta_r;
    span_nxt       = span_r;
    prod_nxt       = prod_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    sat_nxt        = sat_r;
    closed_nxt     = closed_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_busy_nxt   = out_busy_r;
    out_bvalid_nxt = out_bvalid_r;
    out_closed_nxt = out_closed_r;
    case (state_r)
      ST_IDLE:     closed_nxt = 1'b0;
      ST_SW_ADJ:   adj_nxt = adj_val;
      ST_SW_DELTA: begin
        delta_nxt   = dlt_diff[TIME_W] ? '0 : dlt_diff[TIME_W-1:0];
        last_sw_nxt = adj_r;
      end
      ST_CREATE: begin
        if (id_ok) begin
          valid_nxt[id_idx] = 1'b1;
        end
      end
      ST_DELETE: begin
        if (id_ok) begin
          valid_nxt[id_idx] = 1'b0;
        end
      end
      ST_IC_SPAN:  span_nxt = span_diff;
      ST_IC_CHECK: idx_nxt = '0;
      ST_RD: begin
        if (!valid_r[idx_r]) begin
          if (idx_last) begin
            last_win_nxt = now_r;
            closed_nxt   = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_MUL:      prod_nxt = {{SHARE_W{1'b0}}, rt_rd_r} * {{RT_W{1'b0}}, FULL_SCALE};
      ST_PRE: begin
        rem_nxt = {9'b0, prod_r[PROD_W-1:SHARE_W]};
        sat_nxt = pre_sat;
        quo_nxt = '0;
        cnt_nxt = '0;
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? div_sub : div_trial;
        quo_nxt  = {quo_r[SHARE_W-2:0], div_ge};
        prod_nxt = prod_r << 1;
        cnt_nxt  = cnt_r + 1'b1;
      end
      ST_WR: begin
        if (idx_last) begin
          last_win_nxt = now_r;
          closed_nxt   = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RES: begin
        if (res_load) begin
          out_valid_nxt  = 1'b1;
          out_busy_nxt   = busy_ok ? (FULL_SCALE - sh_rd_r) : '0;
          out_bvalid_nxt = busy_ok;
          out_closed_nxt = closed_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      last_sw_r   <= '0;
      last_win_r  <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= WINDOW_RST;
      tick_r      <= TICK_RST;
      idle_r      <= IDLE_RST;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      last_sw_r   <= last_sw_nxt;
      last_win_r  <= last_win_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WINDOW: win_r  <= cfg_data;
          CFG_TICK:   tick_r <= cfg_data[TICK_W-1:0];
          CFG_IDLE:   idle_r <= cfg_data[TID_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      id_r  <= in_thread_id;
      now_r <= in_time_us;
    end
    adj_r        <= adj_nxt;
    delta_r      <= delta_nxt;
    span_r       <= span_nxt;
    prod_r       <= prod_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    idx_r        <= idx_nxt;
    sat_r        <= sat_nxt;
    out_busy_r   <= out_busy_nxt;
    out_bvalid_r <= out_bvalid_nxt;
    out_closed_r <= out_closed_nxt;
  end

  always_ff @(posedge clk) begin
    if (rt_we) begin
      rt_mem[rt_wa] <= rt_wd;
    end
    rt_rd_r <= rt_mem[rt_ra];
    if (sh_we) begin
      sh_mem[sh_wa] <= sh_wd;
    end
    sh_rd_r <= sh_mem[idle_idx];
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the thread CPU usage accounting core: directed table plus random traffic.
module testbench;
  import tcua_pkg::*;

  localparam int FULL_SCALE = 100 << FRAC_DEF;
  localparam int BUSY_W     = $clog2(FULL_SCALE + 1);
  localparam logic [RT_W-1:0]   RT_MAX   = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [BUSY_W-1:0] busy;
    logic              busy_ok;
    logic              closed;
  } usage_t;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] stamp;
    bit                typed;
    logic [BUSY_W-1:0] busy;
    logic              busy_ok;
    logic              closed;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic [ACT_W-1:0]  in_action;
  logic [TID_W-1:0]  in_thread_id;
  logic [TIME_W-1:0] in_time_us;
  logic out_valid, out_ready;
  logic [BUSY_W-1:0] out_busy_percent;
  logic out_busy_valid, out_window_closed;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state and register copies
  logic [RT_W-1:0]   run_us   [THREADS_DEF];
  logic [BUSY_W-1:0] share_q8 [THREADS_DEF];
  logic              slot_live [THREADS_DEF];
  logic [TIME_W-1:0] last_switch_us, last_window_us;
  logic [WIN_W-1:0]  window_cfg;
  logic [TICK_W-1:0] tick_cfg;
  logic [TID_W-1:0]  idle_cfg;

  usage_t pending_usage [$];
  int mismatch_count = 0;
  bit calm_run = 1'b0;
  bit sink_hold_req = 1'b0;
  logic [TIME_W-1:0] time_cursor;

  stim_row_t plan [22] = '{
    '{ACT_SWITCH,   4'd0,  48'd100,              1'b1, 15'd0,     1'b0, 1'b0},
    '{ACT_IDLE_CHK, 4'd0,  48'd0,                1'b1, 15'd0,     1'b0, 1'b0},
    '{ACT_CREATE,   4'd0,  48'd0,                1'b1, 15'd25600, 1'b1, 1'b0},
    '{ACT_CREATE,   4'd15, 48'd0,                1'b1, 15'd25600, 1'b1, 1'b0},
    '{ACT_SWITCH,   4'd0,  48'd500000,           1'b1, 15'd25600, 1'b1, 1'b0},
    '{ACT_SWITCH,   4'd15, 48'd1000000,          1'b1, 15'd25600, 1'b1, 1'b0},
    '{ACT_IDLE_CHK, 4'd0,  48'd999999,           1'b1, 15'd25600, 1'b1, 1'b0},
    '{ACT_IDLE_CHK, 4'd0,  48'd1000000,          1'b0, 15'd0,     1'b0, 1'b0},
    '{ACT_SWITCH,   4'd3,  48'd1000500,          1'b0, 15'd0,     1'b0, 1'b0},
    '{ACT_SWITCH,   4'd0,  48'd1000200,          1'b0, 15'd0,     1'b0, 1'b0},
    '{ACT_SWITCH,   4'd0,  48'd10,               1'b0, 15'd0,     1'b0, 1'b0},
    '{ACT_SWITCH,   4'd15, 48'd3000000,          1'b0, 15'd0,     1'b0, 1'b0},
    '{ACT_IDLE_CHK, 4'd0,  48'd2000000,          1'b0, 15'd0,     1'b0, 1'b0},
    '{ACT_SWITCH,   4'd0,  48'hFFFF_FFFF_FFFF,   1'b0, 15'd0,     1'b0, 1'b0},
    '{ACT_SWITCH,   4'd0,  48'hFFFF_FFFF_FFF0,   1'b0, 15'd0,     1'b0, 1'b0},
    '{ACT_IDLE_CHK, 4'd0,  48'd3000000,          1'b1, 15'd0,     1'b1, 1'b1},
    '{ACT_IDLE_CHK, 4'd0,  48'd3000000,          1'b1, 15'd0,     1'b1, 1'b0},
    '{ACT_DELETE,   4'd0,  48'd0,                1'b1, 15'd0,     1'b0, 1'b0},
    '{ACT_DELETE,   4'd0,  48'd0,                1'b1, 15'd0,     1'b0, 1'b0},
    '{ACT_CREATE,   4'd0,  48'd5,                1'b1, 15'd25600, 1'b1, 1'b0},
    '{ACT_SWITCH,   4'd0,  48'd0,                1'b0, 15'd0,     1'b0, 1'b0},
    '{ACT_DELETE,   4'd7,  48'hFFFF_FFFF_FFFF,   1'b0, 15'd0,     1'b0, 1'b0}
  };

  thread_cpu_usage_accounting_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_thread_id      (in_thread_id),
    .in_time_us        (in_time_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_busy_percent  (out_busy_percent),
    .out_busy_valid    (out_busy_valid),
    .out_window_closed (out_window_closed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic usage_t account_event(input logic [ACT_W-1:0] act,
                                           input logic [TID_W-1:0] tid,
                                           input logic [TIME_W-1:0] stamp);
    usage_t res;
    logic [TIME_W:0] adj;
    logic [TIME_W-1:0] now_adj, delta, span;
    logic [63:0] sum, quo;
    res = '0;
    case (act)
      ACT_SWITCH: begin
        adj = {1'b0, stamp};
        if (stamp < last_switch_us) adj = adj + {{(TIME_W + 1 - TICK_W){1'b0}}, tick_cfg};
        now_adj = adj[TIME_W] ? TIME_MAX : adj[TIME_W-1:0];
        delta = (now_adj >= last_switch_us) ? now_adj - last_switch_us : '0;
        if (slot_live[tid]) begin
          sum = {24'd0, run_us[tid]} + {16'd0, delta};
          run_us[tid] = (sum > {24'd0, RT_MAX}) ? RT_MAX : sum[RT_W-1:0];
        end
        last_switch_us = now_adj;
      end
      ACT_IDLE_CHK: begin
        span = stamp - last_window_us;
        if (stamp > last_window_us && span >= {16'd0, window_cfg}) begin
          for (int i = 0; i < THREADS_DEF; i++) begin
            if (slot_live[i]) begin
              quo = ({24'd0, run_us[i]} * 64'(FULL_SCALE)) / {16'd0, span};
              share_q8[i] = (quo > 64'(FULL_SCALE)) ? BUSY_W'(FULL_SCALE) : quo[BUSY_W-1:0];
              run_us[i] = '0;
            end
          end
          last_window_us = stamp;
          res.closed = 1'b1;
        end
      end
      ACT_CREATE: begin
        run_us[tid] = '0;
        share_q8[tid] = '0;
        slot_live[tid] = 1'b1;
      end
      ACT_DELETE: slot_live[tid] = 1'b0;
      default: ;
    endcase
    if (slot_live[idle_cfg]) begin
      res.busy = BUSY_W'(FULL_SCALE) - share_q8[idle_cfg];
      res.busy_ok = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [TID_W-1:0] live_slot(input logic [TID_W-1:0] start);
    logic [TID_W-1:0] s;
    s = start;
    for (int i = 0; i < THREADS_DEF; i++) begin
      if (slot_live[s]) return s;
      s = s + 1'b1;
    end
    return start;
  endfunction

  task automatic push_item(input logic [ACT_W-1:0] act, input logic [TID_W-1:0] tid,
                           input logic [TIME_W-1:0] stamp, input bit typed,
                           input usage_t want);
    usage_t model_res;
    if (!calm_run && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_thread_id <= tid;
    in_time_us <= stamp;
    do @(posedge clk); while (!in_ready);
    model_res = account_event(act, tid, stamp);
    pending_usage.push_back(typed ? want : model_res);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_usage.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WINDOW: window_cfg = val[WIN_W-1:0];
      CFG_TICK:   tick_cfg = val[TICK_W-1:0];
      CFG_IDLE:   idle_cfg = val[TID_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [WIN_W-1:0] win, input logic [TICK_W-1:0] tick,
                            input logic [TID_W-1:0] idle);
    hold_until_drained();
    repeat (4) @(negedge clk);
    write_reg(CFG_WINDOW, CFG_DATA_W'(win));
    write_reg(CFG_TICK, CFG_DATA_W'(tick));
    write_reg(CFG_IDLE, CFG_DATA_W'(idle));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit pause_midway);
    logic [ACT_W-1:0] act;
    logic [TID_W-1:0] tid;
    logic [TIME_W-1:0] stamp;
    logic [63:0] noise;
    int unsigned pick, step_max, back;
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) hold_until_drained();
      step_max = window_cfg / 3 + 1;
      noise = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      tid = TID_W'($urandom_range(0, THREADS_DEF - 1));
      if (pick < 55) begin
        act = ACT_SWITCH;
        if ($urandom_range(0, 99) < 85) tid = live_slot(tid);
        case ($urandom_range(0, 19))
          0: stamp = noise[TIME_W-1:0];
          1, 2: begin
            back = $urandom_range(0, 2 * tick_cfg + 3);
            stamp = (time_cursor > back) ? time_cursor - back : '0;
          end
          default: begin
            time_cursor += $urandom_range(0, step_max);
            stamp = time_cursor;
          end
        endcase
      end else if (pick < 75) begin
        act = ACT_IDLE_CHK;
        back = $urandom_range(0, step_max);
        if ($urandom_range(0, 4) != 0) begin
          time_cursor += back;
          stamp = time_cursor;
        end else begin
          stamp = (time_cursor > back) ? time_cursor - back : '0;
        end
      end else if (pick < 88) begin
        act = ACT_CREATE;
        if ($urandom_range(0, 2) == 0) tid = idle_cfg;
        stamp = noise[TIME_W-1:0];
      end else begin
        act = ACT_DELETE;
        stamp = noise[TIME_W-1:0];
      end
      push_item(act, tid, stamp, 1'b0, '0);
    end
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ready <= 1'b0;
        for (hold_left = 400; hold_left != 0; hold_left--) @(negedge clk);
      end else if (!calm_run && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    usage_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_busy_percent, out_busy_valid, out_window_closed};
      if (pending_usage.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected transfer busy=%0d valid=%0b closed=%0b",
                   $realtime, got.busy, got.busy_ok, got.closed);
      end else begin
        want = pending_usage.pop_front();
        if (got.busy !== want.busy || got.busy_ok !== want.busy_ok ||
            got.closed !== want.closed) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp busy=%0d valid=%0b closed=%0b, got busy=%0d valid=%0b closed=%0b",
                     $realtime, want.busy, want.busy_ok, want.closed,
                     got.busy, got.busy_ok, got.closed);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_SWITCH;
    in_thread_id = '0;
    in_time_us = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WINDOW;
    cfg_data = '0;
    window_cfg = WINDOW_RST;
    tick_cfg = TICK_RST;
    idle_cfg = IDLE_RST;
    last_switch_us = '0;
    last_window_us = '0;
    time_cursor = '0;
    for (int i = 0; i < THREADS_DEF; i++) begin
      run_us[i] = '0;
      share_q8[i] = '0;
      slot_live[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[r])
      push_item(plan[r].act, plan[r].tid, plan[r].stamp, plan[r].typed,
                {plan[r].busy, plan[r].busy_ok, plan[r].closed});

    time_cursor = 48'd3000000;
    set_config(32'd5000, 20'd0, 4'd3);
    sink_hold_req = 1'b1;
    run_random(150, 1'b0);

    set_config(32'd1, 20'd1000000, 4'd15);
    run_random(150, 1'b1);

    set_config(32'hFFFF_FFFF, 20'd777, 4'd0);
    run_random(100, 1'b0);

    set_config(WIN_W'($urandom_range(16, 20000)), TICK_W'($urandom_range(0, 1000000)),
               TID_W'($urandom_range(0, THREADS_DEF - 1)));
    calm_run = 1'b1;
    run_random(200, 1'b0);

    hold_until_drained();
    repeat (350) @(negedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
